// ===== design/cvsq_pkg.sv =====
// Package for the pitch CV scale quantizer: fixed-point constants, scale tables,
// register index codes and the output lookup table.
// No dependencies; used by cv_scale_quantizer.
`timescale 1ns / 1ps

package cvsq_pkg;

    // Fixed-point format of every CV and mod value
    localparam int CV_FRAC_BITS = 16;
    localparam int CV_ONE_INT   = 1 << CV_FRAC_BITS;
    localparam logic [16:0] CV_ONE = 17'(CV_ONE_INT);

    // Musical constants
    localparam int NUM_SCALES      = 5;
    localparam int SEMIS_PER_OCT   = 12;
    localparam int SEMIS_PER_RANGE = 60;
    localparam int MAX_SCALE_LEN   = 12;

    typedef logic [2:0] scale_idx_t;
    typedef logic [3:0] semi_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BASE_SCALE         = 3'd0,
        REG_BASE_ROOT          = 3'd1,
        REG_SCALE_MOD_KNOB     = 3'd2,
        REG_ROOT_MOD_KNOB      = 3'd3,
        REG_SCALE_MOD_EXTERNAL = 3'd4,
        REG_ROOT_MOD_EXTERNAL  = 3'd5
    } cfg_reg_t;

    // Scale note tables; unused tail entries are never selected
    typedef semi_t scale_row_t [MAX_SCALE_LEN];
    typedef scale_row_t scale_tbl_t [NUM_SCALES];

    localparam scale_tbl_t SCALE_NOTES = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    typedef logic [3:0] scale_len_t [NUM_SCALES];
    localparam scale_len_t SCALE_LEN = '{4'd12, 4'd7, 4'd7, 4'd5, 4'd5};

    // Semitone count to output CV, round half up, clamped to full scale
    typedef logic [16:0] cv_lut_t [64];

    function automatic cv_lut_t build_cv_lut();
        cv_lut_t lut;
        longint  v;
        for (int i = 0; i < 64; i++) begin
            v = (longint'(i) * CV_ONE_INT + SEMIS_PER_RANGE / 2) / SEMIS_PER_RANGE;
            if (v > CV_ONE_INT) begin
                v = CV_ONE_INT;
            end
            lut[i] = 17'(v);
        end
        return lut;
    endfunction

    localparam cv_lut_t CV_LUT = build_cv_lut();

    // Clamp a signed Q value to 0..ONE
    function automatic logic [16:0] clamp_unit(input logic signed [17:0] v);
        logic [16:0] r;
        if (v < 0) begin
            r = '0;
        end
        else if (v > $signed({1'b0, CV_ONE})) begin
            r = CV_ONE;
        end
        else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

// ===== design/cv_scale_quantizer.sv =====
// Pitch CV scale quantizer, top level: three-stage pipeline with config registers.
// Depends on cvsq_pkg.
`timescale 1ns / 1ps

// Quantizes a signed Q16 pitch CV onto the nearest note of one of five scales
// (chromatic, major, minor, major pentatonic, minor pentatonic) over a five-octave
// range, adds the root and returns a Q16 CV clamped to 1.0 together with the scale
// and root actually used. Scale and root are the base registers plus a knob or CV
// modulation amount, wrapped. Throughput is one word per clock while the output is not
// stalled; an accepted input word passes through the three pipeline registers
// (mod/octave split, nearest-note search, output lookup) before its result is valid. A stalled
// output holds the pipeline; empty stages still fill while the output is stalled.
// Configuration is always ready and takes effect for words accepted afterwards.
module cv_scale_quantizer (
    input  logic               clk,
    input  logic               rst_n,
    // input word
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [17:0] cv_in,
    input  logic signed [17:0] scale_mod_cv,
    input  logic signed [17:0] root_mod_cv,
    // result word
    output logic               result_valid,
    input  logic               result_stall,
    output logic [16:0]        cv_out,
    output logic [2:0]         scale_used,
    output logic [3:0]         root_used,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    typedef struct packed {
        cvsq_pkg::scale_idx_t sc;
        cvsq_pkg::semi_t      rt;
        logic [2:0]           octave;
        logic [19:0]          note12;   // 12 * fraction of octave, Q16 semitones
    } stage_a_t;

    typedef struct packed {
        cvsq_pkg::scale_idx_t sc;
        cvsq_pkg::semi_t      rt;
        logic [2:0]           octave;
        cvsq_pkg::semi_t      best;
    } stage_b_t;

    // ---------------- configuration registers ----------------
    logic [2:0]  base_scale_reg;
    logic [3:0]  base_root_reg;
    logic [16:0] scale_mod_knob_reg;
    logic [16:0] root_mod_knob_reg;
    logic        scale_mod_external_reg;
    logic        root_mod_external_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_scale_reg         <= '0;
            base_root_reg          <= '0;
            scale_mod_knob_reg     <= '0;
            root_mod_knob_reg      <= '0;
            scale_mod_external_reg <= 1'b0;
            root_mod_external_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cvsq_pkg::cfg_reg_t'(cfg_index))
                cvsq_pkg::REG_BASE_SCALE:         base_scale_reg         <= cfg_data[2:0];
                cvsq_pkg::REG_BASE_ROOT:          base_root_reg          <= cfg_data[3:0];
                cvsq_pkg::REG_SCALE_MOD_KNOB:     scale_mod_knob_reg     <= cfg_data;
                cvsq_pkg::REG_ROOT_MOD_KNOB:      root_mod_knob_reg      <= cfg_data;
                cvsq_pkg::REG_SCALE_MOD_EXTERNAL: scale_mod_external_reg <= cfg_data[0];
                cvsq_pkg::REG_ROOT_MOD_EXTERNAL:  root_mod_external_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic va_reg, vb_reg, vc_reg;
    logic ready_a, ready_b, ready_c;

    assign ready_c    = !vc_reg || !result_stall;
    assign ready_b    = !vb_reg || ready_c;
    assign ready_a    = !va_reg || ready_b;
    assign item_stall = !ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a) va_reg <= item_valid;
            if (ready_b) vb_reg <= va_reg;
            if (ready_c) vc_reg <= vb_reg;
        end
    end

    // ---------------- stage A: mod select, wrap, octave split ----------------
    logic [16:0] smod, rmod, xcl;
    logic [19:0] smod_x5, x_x5;
    logic [20:0] rmod_x12;
    logic [3:0]  scale_sum;
    logic [4:0]  root_sum;
    logic [15:0] frac;
    stage_a_t    a_next, a_reg;

    always_comb
    begin
        smod = cvsq_pkg::clamp_unit(scale_mod_external_reg ? scale_mod_cv
                                    : $signed({1'b0, scale_mod_knob_reg}));
        rmod = cvsq_pkg::clamp_unit(root_mod_external_reg ? root_mod_cv
                                    : $signed({1'b0, root_mod_knob_reg}));
        xcl  = cvsq_pkg::clamp_unit(cv_in);

        // floor(mod * 5) and floor(mod * 12) in Q16
        smod_x5  = 20'({smod, 2'b00}) + 20'(smod);
        rmod_x12 = 21'({rmod, 3'b000}) + 21'({rmod, 2'b00});

        // wrap scale modulo 5 (sum is at most 12)
        scale_sum = 4'(base_scale_reg) + smod_x5[19:16];
        if (scale_sum >= 4'(2 * cvsq_pkg::NUM_SCALES))
            a_next.sc = 3'(scale_sum - 4'(2 * cvsq_pkg::NUM_SCALES));
        else if (scale_sum >= 4'(cvsq_pkg::NUM_SCALES))
            a_next.sc = 3'(scale_sum - 4'(cvsq_pkg::NUM_SCALES));
        else
            a_next.sc = 3'(scale_sum);

        // wrap root modulo 12 (sum is at most 27)
        root_sum = 5'(base_root_reg) + rmod_x12[20:16];
        if (root_sum >= 5'(2 * cvsq_pkg::SEMIS_PER_OCT))
            a_next.rt = 4'(root_sum - 5'(2 * cvsq_pkg::SEMIS_PER_OCT));
        else if (root_sum >= 5'(cvsq_pkg::SEMIS_PER_OCT))
            a_next.rt = 4'(root_sum - 5'(cvsq_pkg::SEMIS_PER_OCT));
        else
            a_next.rt = 4'(root_sum);

        // x * 60 split into octaves: octave = floor(x * 5), remainder times 12
        x_x5          = 20'({xcl, 2'b00}) + 20'(xcl);
        a_next.octave = x_x5[18:16];
        frac          = x_x5[15:0];
        a_next.note12 = 20'({frac, 3'b000}) + 20'({frac, 2'b00});
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && item_valid) a_reg <= a_next;
    end

    // ---------------- stage B: nearest scale note ----------------
    // Notes are sorted, so the winner is the highest note whose midpoint with its
    // lower neighbor is strictly exceeded; a tie keeps the lower note.
    logic [20:0] note_x2;
    logic [4:0]  mid_sum;
    stage_b_t    b_next, b_reg;

    always_comb
    begin
        b_next.sc     = a_reg.sc;
        b_next.rt     = a_reg.rt;
        b_next.octave = a_reg.octave;
        b_next.best   = cvsq_pkg::SCALE_NOTES[a_reg.sc][0];
        note_x2       = {a_reg.note12, 1'b0};
        mid_sum       = '0;
        for (int i = 1; i < cvsq_pkg::MAX_SCALE_LEN; i++)
        begin
            mid_sum = 5'(cvsq_pkg::SCALE_NOTES[a_reg.sc][i - 1])
                    + 5'(cvsq_pkg::SCALE_NOTES[a_reg.sc][i]);
            if ((4'(i) < cvsq_pkg::SCALE_LEN[a_reg.sc]) &&
                (note_x2 > {mid_sum, 16'h0000}))
                b_next.best = cvsq_pkg::SCALE_NOTES[a_reg.sc][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && va_reg) b_reg <= b_next;
    end

    // ---------------- stage C: semitones to output CV ----------------
    logic [6:0]  semis;
    logic [16:0] cv_next;
    logic [16:0] cv_out_reg;
    logic [2:0]  scale_used_reg;
    logic [3:0]  root_used_reg;

    always_comb
    begin
        semis = 7'({b_reg.octave, 2'b00}) + 7'({b_reg.octave, 3'b000})
              + 7'(b_reg.best) + 7'(b_reg.rt);
        if (semis >= 7'(cvsq_pkg::SEMIS_PER_RANGE))
            cv_next = cvsq_pkg::CV_ONE;
        else
            cv_next = cvsq_pkg::CV_LUT[semis[5:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && vb_reg)
        begin
            cv_out_reg     <= cv_next;
            scale_used_reg <= b_reg.sc;
            root_used_reg  <= b_reg.rt;
        end
    end

    assign result_valid = vc_reg;
    assign cv_out       = cv_out_reg;
    assign scale_used   = scale_used_reg;
    assign root_used    = root_used_reg;

`ifndef SYNTH
    // input back-pressure only when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (va_reg && vb_reg && vc_reg && result_stall))
        else $error("input stalled with room in the pipeline");

    // wrapped scale and root stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (scale_used < 3'(cvsq_pkg::NUM_SCALES) &&
                          root_used < 4'(cvsq_pkg::SEMIS_PER_OCT)))
        else $error("scale or root out of range");

    // output CV never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cv_out <= cvsq_pkg::CV_ONE))
        else $error("cv_out above full scale");

    // a word in stage B with an open output reaches the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && ready_c) |=> result_valid)
        else $error("word lost between stage B and output");
`endif

endmodule
